// ===== hw/rtl/semq_pkg.sv =====
// Shared types and constants of the counting semaphore with its wait queue.
package semq_pkg;

  // Width of the initial count register as seen on the configuration port.
  localparam int CFG_BITS           = 16;
  localparam int STATUS_BITS        = 3;
  localparam int DEF_QUEUE_DEPTH    = 16;
  localparam int DEF_THREAD_ID_BITS = 8;
  localparam int DEF_COUNT_BITS     = 16;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_GRANTED     = 3'd0,
    ST_BLOCKED     = 3'd1,
    ST_INCREMENTED = 3'd2,
    ST_WOKE        = 3'd3,
    ST_NOT_READY   = 3'd4,
    ST_QUEUE_FULL  = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } semq_cmd_t;

endpackage

// ===== hw/rtl/semq_ctrl.sv =====
// Controller state machine: sequences capture and execution of each request.
module semq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output semq_pkg::semq_cmd_t cmd
);
  import semq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
        cmd.execute = 1'b0;
      end
      S_EXEC: begin
        busy        = 1'b1;
        cmd.capture = 1'b0;
        cmd.execute = 1'b1;
      end
      default: begin
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/semq_dp.sv =====
// Datapath: semaphore count, wait queue memory with its pointers, result registers.
module semq_dp #(
  parameter int QUEUE_DEPTH    = semq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = semq_pkg::DEF_THREAD_ID_BITS,
  parameter int COUNT_BITS     = semq_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  semq_pkg::semq_cmd_t                 cmd,
  input  logic                                in_op,
  input  logic [THREAD_ID_BITS-1:0]           in_thread_id,
  input  logic                                cfg_we,
  input  logic [semq_pkg::CFG_BITS-1:0]       cfg_wdata,
  output logic                                out_valid,
  output logic [semq_pkg::STATUS_BITS-1:0]    out_status,
  output logic [THREAD_ID_BITS-1:0]           out_woken_thread,
  output logic [COUNT_BITS-1:0]               out_count_after,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_waiters_after
);
  import semq_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0]   LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [OCC_BITS-1:0]   FULL_OCC  = OCC_BITS'(QUEUE_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [THREAD_ID_BITS-1:0] wait_mem [QUEUE_DEPTH];

  logic [COUNT_BITS-1:0]     count_r, count_nxt;
  logic                      ready_r, ready_nxt;
  logic [PTR_BITS-1:0]       head_r, head_nxt;
  logic [PTR_BITS-1:0]       tail_r, tail_nxt;
  logic [OCC_BITS-1:0]       occ_r, occ_nxt;
  logic                      op_r;
  logic [THREAD_ID_BITS-1:0] tid_r;
  logic [THREAD_ID_BITS-1:0] head_data_r;
  logic                      push;
  status_t                   status_nxt;
  logic [THREAD_ID_BITS-1:0] woken_nxt;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [THREAD_ID_BITS-1:0] out_woken_r;
  logic [COUNT_BITS-1:0]     out_count_r;
  logic [OCC_BITS-1:0]       out_occ_r;

  always_comb begin
    count_nxt  = count_r;
    ready_nxt  = ready_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    push       = 1'b0;
    status_nxt = ST_NOT_READY;
    woken_nxt  = '0;
    if (cfg_we) begin
      count_nxt = COUNT_BITS'(cfg_wdata);
      ready_nxt = 1'b1;
    end else if (cmd.execute && ready_r) begin
      if (op_r == OP_ACQUIRE) begin
        if (count_r != '0) begin
          count_nxt  = count_r - COUNT_BITS'(1);
          status_nxt = ST_GRANTED;
        end else if (occ_r == FULL_OCC) begin
          status_nxt = ST_QUEUE_FULL;
        end else begin
          push       = 1'b1;
          tail_nxt   = (tail_r == LAST_SLOT) ? '0 : tail_r + PTR_BITS'(1);
          occ_nxt    = occ_r + OCC_BITS'(1);
          status_nxt = ST_BLOCKED;
        end
      end else begin
        if (occ_r == '0) begin
          if (count_r == COUNT_MAX) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            count_nxt  = count_r + COUNT_BITS'(1);
            status_nxt = ST_INCREMENTED;
          end
        end else begin
          // The head entry was read out when the request was taken in.
          woken_nxt  = head_data_r;
          head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + PTR_BITS'(1);
          occ_nxt    = occ_r - OCC_BITS'(1);
          status_nxt = ST_WOKE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      wait_mem[tail_r] <= tid_r;
    end
    head_data_r <= wait_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      tid_r <= in_thread_id;
    end
    if (cmd.execute) begin
      out_status_r <= status_nxt;
      out_woken_r  <= woken_nxt;
      out_count_r  <= count_nxt;
      out_occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= cmd.execute;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_woken_thread  = out_woken_r;
  assign out_count_after   = out_count_r;
  assign out_waiters_after = out_occ_r;

endmodule

// ===== hw/rtl/counting_semaphore_wait_queue_top.sv =====
// Top level of the counting semaphore with a first-in first-out wait queue.
//
// Usage: write the initial count on cfg_wdata with cfg_we high for one cycle;
// this loads the count and marks the semaphore ready, leaving any waiters
// queued. Configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this. A request transaction
// (in_op: acquire or release, in_thread_id) is taken at a rising edge where
// start is high and busy is low. Its one result appears on the out_ ports,
// marked by out_valid for exactly one cycle; the receiver cannot hold it off.
// Each request is handled in two steps: one captures it while the wait queue
// memory reads its head entry, one updates the count and queue pointers.
// busy is high during the second; a new request may be accepted in the same
// cycle that the previous result is shown, but not while one is executing.
// Requests made before the first configuration write report not ready.
// After reset (rst_n low, synchronous) the count is zero, the block is not
// ready and the wait queue is empty; queue memory contents are not cleared.
module counting_semaphore_wait_queue_top #(
  parameter int QUEUE_DEPTH    = semq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = semq_pkg::DEF_THREAD_ID_BITS,
  parameter int COUNT_BITS     = semq_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [THREAD_ID_BITS-1:0]           in_thread_id,
  input  logic                                cfg_we,
  input  logic [semq_pkg::CFG_BITS-1:0]       cfg_wdata,
  output logic                                out_valid,
  output logic [semq_pkg::STATUS_BITS-1:0]    out_status,
  output logic [THREAD_ID_BITS-1:0]           out_woken_thread,
  output logic [COUNT_BITS-1:0]               out_count_after,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_waiters_after
);
  import semq_pkg::*;

  semq_cmd_t cmd;

  semq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  semq_dp #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_thread_id      (in_thread_id),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_woken_thread  (out_woken_thread),
    .out_count_after   (out_count_after),
    .out_waiters_after (out_waiters_after)
  );

endmodule

// ===== hw/rtl/semq_chk.sv =====
// Port-level checker for the semaphore top level, bound to it below.
module semq_chk #(
  parameter int QUEUE_DEPTH    = semq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = semq_pkg::DEF_THREAD_ID_BITS,
  parameter int COUNT_BITS     = semq_pkg::DEF_COUNT_BITS
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [semq_pkg::STATUS_BITS-1:0]    out_status,
  input logic [THREAD_ID_BITS-1:0]           out_woken_thread,
  input logic [COUNT_BITS-1:0]               out_count_after,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_waiters_after
);
  import semq_pkg::*;

  // An accepted transaction always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Every busy cycle ends in exactly one result and frees the block.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle not followed by a result");

  // A woken identifier is only reported alongside the woke status.
  a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_WOKE) |-> (out_woken_thread == '0))
    else $error("woken thread non-zero without a wake");

  // Nothing can be queued before the semaphore is initialised.
  a_not_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NOT_READY) |-> (out_waiters_after == '0))
    else $error("waiters reported before initialisation");

  // An overflowing release leaves the count saturated at its maximum.
  a_overflow_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVERFLOW) |-> (out_count_after == '1))
    else $error("overflow reported without a saturated count");

endmodule

bind counting_semaphore_wait_queue_top semq_chk #(
  .QUEUE_DEPTH    (QUEUE_DEPTH),
  .THREAD_ID_BITS (THREAD_ID_BITS),
  .COUNT_BITS     (COUNT_BITS)
) u_semq_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_woken_thread  (out_woken_thread),
  .out_count_after   (out_count_after),
  .out_waiters_after (out_waiters_after)
);
